### src/inflight_credit_pacing_limiter_assert.svh
// Assertion macros shared by the checker of the in-flight credit pacing limiter.
// Depends on nothing; every macro expects a clk and an rst in scope.
`ifndef INFLIGHT_CREDIT_PACING_LIMITER_ASSERT_SVH
`define INFLIGHT_CREDIT_PACING_LIMITER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ICPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ICPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/icpl_pkg.sv
// Package of the in-flight credit pacing limiter: types, codes and constants.
// Used by the divider, the limiter top and the checker; depends on nothing.
package icpl_pkg;

  // Width of the shared divider.
  localparam int DIV_W = 64;

  // Q0.16 factors.
  localparam logic [15:0] F_START = 16'd32768;
  localparam logic [15:0] F_FINAL = 16'd58982;
  localparam logic [15:0] F_AVG   = 16'd45875;
  localparam logic [15:0] F_DELTA = 16'd26214;

  // Result status codes.
  localparam logic [1:0] ST_GRANT    = 2'd0;
  localparam logic [1:0] ST_HOLD_CRD = 2'd1;
  localparam logic [1:0] ST_HOLD_MEM = 2'd2;
  localparam logic [1:0] ST_FEEDBACK = 2'd3;

  // Request kinds.
  localparam logic CMD_FEEDBACK = 1'b0;
  localparam logic CMD_PUBLISH  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_IN_FLIGHT   = 2'd0;
  localparam logic [1:0] REG_MIN_FREE_MEMORY = 2'd1;
  localparam logic [1:0] REG_SMOOTH_ENABLE   = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/icpl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module icpl_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/icpl_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on icpl_pkg.
module icpl_div import icpl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder,
  output div_stat_t        stat
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem[DIV_W-1:0], quo[DIV_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (go) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(DIV_W);
      end else if (stat.busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= dividend;
    end else if (stat.busy) begin
      rem <= fits ? diff : trial;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem[DIV_W-1:0];

endmodule

### src/inflight_credit_pacing_limiter.sv
// Feedback, holds and unpaced grants go from the idle state straight to the output state,
// where the result is registered. Paced grants run up to five divisions on the shared
// divider; one request is worked on at a time.
// The result register lets the next request be taken while a result waits.
// Reset (rst, synchronous) clears counters, pacing state and configuration;
// the grant-time ring is not cleared and needs no clearing pass.
module inflight_credit_pacing_limiter import icpl_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int COUNT_WIDTH = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [47:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // consumed_total, now_time, free_memory
  input  logic         s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // wait_time, in_flight, zero fill
  output logic [1:0]   m_axis_tuser   // status
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = COUNT_WIDTH;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SLOT = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_RD2  = 5'd3;
  localparam logic [4:0] S_PER  = 5'd4;
  localparam logic [4:0] S_AVG  = 5'd5;
  localparam logic [4:0] S_FMUL = 5'd6;
  localparam logic [4:0] S_FGO  = 5'd7;
  localparam logic [4:0] S_FDIV = 5'd8;
  localparam logic [4:0] S_CMUL = 5'd9;
  localparam logic [4:0] S_LMUL = 5'd10;
  localparam logic [4:0] S_PMUL = 5'd11;
  localparam logic [4:0] S_PGO  = 5'd12;
  localparam logic [4:0] S_PDIV = 5'd13;
  localparam logic [4:0] S_WAIT = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  logic [4:0]  state;

  logic [6:0]  cfg_max;
  logic [47:0] cfg_mem;
  logic        cfg_smooth;

  logic [CW-1:0] sent;
  logic [CW-1:0] consumed;
  logic [6:0]    window_size;
  logic [CW-1:0] counting_since;
  logic [39:0]   first_time;
  logic [39:0]   last_time;
  logic [39:0]   pacing_delay;

  logic [39:0]   now_r;
  logic [AW-1:0] slot_r;
  logic [47:0]   per_item;
  logic [47:0]   avg;
  logic [15:0]   factor;
  logic [47:0]   cand;
  logic [1:0]    res_status;
  logic [31:0]   res_wait;

  logic [47:0] mul_a;
  logic [15:0] mul_b;
  logic [63:0] prod;

  logic             div_go;
  logic [DIV_W-1:0] div_a;
  logic [DIV_W-1:0] div_b;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] div_r;
  div_stat_t        div_stat;

  logic [39:0] rd_data;

  logic [39:0] in_consumed;
  logic [39:0] in_now;
  logic [47:0] in_free;

  logic [CW-1:0] diff;
  logic          diff_neg;
  logic [CW-1:0] win_n;
  logic [8:0]    m3;
  logic          hold_crd;
  logic          hold_mem;
  logic          pace_on;
  logic [47:0]   low;
  logic [47:0]   clamped;
  logic [47:0]   elapsed;
  logic [47:0]   delay_w;
  logic [6:0]    flight;

  assign in_consumed = s_axis_tdata[39:0];
  assign in_now      = s_axis_tdata[79:40];
  assign in_free     = s_axis_tdata[127:80];

  assign s_axis_tready = (state == S_IDLE);

  function automatic logic [39:0] sat40(input logic [DIV_W-1:0] v);
    sat40 = (|v[DIV_W-1:40]) ? '1 : v[39:0];
  endfunction

  always_comb begin
    diff     = sent - consumed;
    diff_neg = diff[CW-1];
    win_n    = sent - counting_since;
    m3       = {2'b00, cfg_max} + {1'b0, cfg_max, 1'b0};
    hold_crd = (cfg_max != '0) && !diff_neg && (diff >= CW'(cfg_max));
    hold_mem = (cfg_mem != '0) && !(in_free > cfg_mem);
    pace_on  = (cfg_max != '0) && cfg_smooth && (32'(cfg_max) <= MAX_WINDOW);
    low      = prod[63:16];
    // Upper bound wins over the lower one.
    if (cand > avg) begin
      clamped = avg;
    end else if (cand < low) begin
      clamped = low;
    end else begin
      clamped = cand;
    end
    elapsed = {now_r - last_time, 8'b0};
    delay_w = {8'b0, pacing_delay};
    if (diff_neg) begin
      flight = '0;
    end else if (diff > CW'(64)) begin
      flight = 7'd64;
    end else begin
      flight = diff[6:0];
    end
  end

  // Operands of the shared multiplier; the product is registered and ready in the next cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_FMUL: begin
        mul_a = 48'(sent - CW'(cfg_max));
        mul_b = F_DELTA;
      end
      S_CMUL: begin
        mul_a = per_item;
        mul_b = factor;
      end
      S_LMUL: begin
        mul_a = avg;
        mul_b = F_AVG;
      end
      S_PMUL: begin
        mul_a = {8'b0, pacing_delay};
        mul_b = {9'b0, cfg_max - 7'd1};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  icpl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .quotient  (div_q),
    .remainder (div_r),
    .stat      (div_stat)
  );

  icpl_ram #(
    .WIDTH (40),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_FIN),
    .waddr (slot_r),
    .wdata (now_r),
    .raddr (slot_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cfg_max        <= '0;
      cfg_mem        <= '0;
      cfg_smooth     <= 1'b0;
      sent           <= '0;
      consumed       <= '0;
      window_size    <= '0;
      counting_since <= '0;
      first_time     <= '0;
      last_time      <= '0;
      pacing_delay   <= '0;
      div_go         <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_IN_FLIGHT:   cfg_max    <= cfg_data[6:0];
          REG_MIN_FREE_MEMORY: cfg_mem    <= cfg_data;
          REG_SMOOTH_ENABLE:   cfg_smooth <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            now_r    <= in_now;
            res_wait <= '0;
            state    <= S_OUT;
            if (s_axis_tuser == CMD_FEEDBACK) begin
              consumed   <= CW'(in_consumed);
              res_status <= ST_FEEDBACK;
            end else if (cfg_max == '0 && cfg_mem == '0) begin
              res_status <= ST_GRANT;
            end else if (hold_crd) begin
              res_status <= ST_HOLD_CRD;
            end else if (hold_mem) begin
              res_status <= ST_HOLD_MEM;
            end else if (pace_on) begin
              if (window_size != cfg_max) begin
                window_size    <= cfg_max;
                counting_since <= sent;
                first_time     <= in_now;
              end
              div_go <= 1'b1;
              div_a  <= DIV_W'(sent);
              div_b  <= DIV_W'(cfg_max);
              state  <= S_SLOT;
            end else begin
              sent       <= sent + CW'(1);
              res_status <= ST_GRANT;
            end
          end
        end
        S_SLOT: begin
          if (div_stat.done) begin
            slot_r <= div_r[AW-1:0];
            state  <= S_RD;
          end
        end
        S_RD: state <= S_RD2;
        S_RD2: begin
          if (win_n < CW'(cfg_max)) begin
            state <= S_FIN;
          end else begin
            div_go <= 1'b1;
            div_a  <= DIV_W'({now_r - rd_data, 8'b0});
            div_b  <= DIV_W'(cfg_max);
            state  <= S_PER;
          end
        end
        S_PER: begin
          if (div_stat.done) begin
            per_item <= div_q[47:0];
            div_go   <= 1'b1;
            div_a    <= DIV_W'({now_r - first_time, 8'b0});
            div_b    <= DIV_W'(win_n);
            state    <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_stat.done) begin
            avg <= div_q[47:0];
            if (pacing_delay == '0) begin
              pacing_delay <= sat40(DIV_W'(per_item[47:1]));
              state        <= S_WAIT;
            end else if (sent < CW'(cfg_max)) begin
              factor <= F_START;
              state  <= S_CMUL;
            end else if (sent >= CW'(m3)) begin
              factor <= F_FINAL;
              state  <= S_CMUL;
            end else begin
              state <= S_FMUL;
            end
          end
        end
        S_FMUL: state <= S_FGO;
        S_FGO: begin
          div_go <= 1'b1;
          div_a  <= prod;
          div_b  <= DIV_W'({cfg_max, 1'b0});
          state  <= S_FDIV;
        end
        S_FDIV: begin
          if (div_stat.done) begin
            factor <= F_START + div_q[15:0];
            state  <= S_CMUL;
          end
        end
        S_CMUL: state <= S_LMUL;
        S_LMUL: begin
          cand  <= prod[63:16];
          state <= S_PMUL;
        end
        S_PMUL: begin
          cand  <= clamped;
          state <= S_PGO;
        end
        S_PGO: begin
          div_go <= 1'b1;
          div_a  <= prod + DIV_W'(cand);
          div_b  <= DIV_W'(cfg_max);
          state  <= S_PDIV;
        end
        S_PDIV: begin
          if (div_stat.done) begin
            pacing_delay <= sat40(div_q);
            state        <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (elapsed < delay_w) begin
            res_wait <= 32'((delay_w - elapsed) >> 8);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          last_time  <= now_r + 40'(res_wait);
          sent       <= sent + CW'(1);
          res_status <= ST_GRANT;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {1'b0, flight, res_wait};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/icpl_checker.sv
// Port-level checker of the in-flight credit pacing limiter, bound to the top.
// Depends on icpl_pkg and inflight_credit_pacing_limiter_assert.svh.
`include "inflight_credit_pacing_limiter_assert.svh"

module icpl_checker import icpl_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // Only a granted request may carry a wait.
  `ICPL_ASSERT_IMP(a_wait_only_grant, m_axis_tvalid && m_axis_tuser != ST_GRANT, m_axis_tdata[31:0] == '0, "wait on a result that is not a grant")

  // The in-flight count saturates at 64.
  `ICPL_ASSERT_IMP(a_flight_sat, m_axis_tvalid, m_axis_tdata[38:32] <= 7'd64, "in_flight above 64")

  // A stalled result holds.
  `ICPL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // The block is busy in the cycle after it takes a request.
  `ICPL_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready straight after a request was taken")

endmodule

bind inflight_credit_pacing_limiter icpl_checker u_icpl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/tb_top.sv
// Self-checking testbench of the in-flight credit pacing limiter.
// Depends on icpl_pkg and the block itself; predicts every result and checks it in order.
`timescale 1ns / 100ps

module tb_top;
  import icpl_pkg::*;

  localparam logic [63:0] T_MASK = 64'hFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic        cmd;
    logic [39:0] consumed_total;
    logic [39:0] now_time;
    logic [47:0] free_memory;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] wait_time;
    logic [6:0]  in_flight;
  } verdict_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [47:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // consumed_total, now_time, free_memory
  logic         s_axis_tuser = 1'b0;  // cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;  // wait_time, in_flight, zero fill
  logic [1:0]   m_axis_tuser;  // status

  inflight_credit_pacing_limiter u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t pending_requests[$];
  verdict_t expected_verdicts[$];
  int errors = 0;
  bit calm = 0;

  // Shadow of the block's configuration and state.
  logic [63:0] lim_r, floor_r, smooth_r;
  logic [63:0] sent_cnt, done_cnt, win_size, win_start, first_t, last_t, delay_q8;
  logic [63:0] grant_ring[64];

  function automatic logic [6:0] credit_in_use();
    logic [63:0] d;
    d = (sent_cnt - done_cnt) & T_MASK;
    if (d[39]) return 7'd0;
    return (d > 64) ? 7'd64 : d[6:0];
  endfunction

  function automatic logic [63:0] pace_grant(logic [63:0] now, logic [63:0] m);
    logic [63:0] wt, slot, n, iter, per_item, avg, elapsed, factor, cand, low;
    wt = 0;
    slot = sent_cnt % m;
    if (win_size != m) begin
      win_size = m;
      win_start = sent_cnt;
      first_t = now;
    end
    n = (sent_cnt - win_start) & T_MASK;
    if (n >= m) begin
      iter = (now - grant_ring[slot[5:0]]) & T_MASK;
      per_item = (iter << 8) / m;
      avg = (((now - first_t) & T_MASK) << 8) / n;
      if (delay_q8 == 0) begin
        delay_q8 = (per_item * F_START) >> 16;
      end else begin
        if (sent_cnt < m) factor = F_START;
        else if (sent_cnt >= 3 * m) factor = F_FINAL;
        else factor = F_START + ((F_FINAL - F_START) * (sent_cnt - m)) / (2 * m);
        cand = (per_item * factor) >> 16;
        low = (avg * F_AVG) >> 16;
        if (cand > avg) cand = avg;
        else if (cand < low) cand = low;
        delay_q8 = ((m - 1) * delay_q8 + cand) / m;
      end
      if (delay_q8 > T_MASK) delay_q8 = T_MASK;
      elapsed = ((now - last_t) & T_MASK) << 8;
      if (elapsed < delay_q8) wt = (delay_q8 - elapsed) >> 8;
    end
    last_t = (now + wt) & T_MASK;
    grant_ring[slot[5:0]] = now;
    return wt;
  endfunction

  function automatic verdict_t gate_request(request_t r);
    verdict_t v;
    logic [63:0] d, wt;
    wt = 0;
    v.status = ST_GRANT;
    if (r.cmd == CMD_FEEDBACK) begin
      done_cnt = 64'(r.consumed_total);
      v.status = ST_FEEDBACK;
    end else if (lim_r != 0 || floor_r != 0) begin
      d = (sent_cnt - done_cnt) & T_MASK;
      if (lim_r != 0 && !d[39] && d >= lim_r) begin
        v.status = ST_HOLD_CRD;
      end else if (floor_r != 0 && !(r.free_memory > floor_r)) begin
        v.status = ST_HOLD_MEM;
      end else begin
        if (lim_r != 0 && smooth_r != 0 && lim_r <= 64) wt = pace_grant(r.now_time, lim_r);
        sent_cnt = (sent_cnt + 1) & T_MASK;
      end
    end
    v.wait_time = wt[31:0];
    v.in_flight = credit_in_use();
    return v;
  endfunction

  // Input side: acceptance seen at the rising edge, driving at the falling edge.
  bit s_took, m_took;
  int s_gap = 0, m_gap = 0;
  request_t head;

  always @(posedge clk) begin
    s_took <= s_axis_tvalid && s_axis_tready;
    m_took <= m_axis_tvalid && m_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready)
      expected_verdicts.push_back(gate_request(request_t'({s_axis_tuser, s_axis_tdata[39:0],
                                  s_axis_tdata[79:40], s_axis_tdata[127:80]})));
  end

  always @(negedge clk) begin
    if (!rst && !(s_axis_tvalid && !s_took)) begin
      if (s_axis_tvalid) s_gap = calm ? 0 : $urandom_range(0, 9);
      if (s_gap > 0) begin
        s_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        head = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= head.cmd;
        s_axis_tdata <= {head.free_memory, head.now_time, head.consumed_total};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random back-pressure, one draw per result.
  always @(negedge clk) begin
    if (!rst) begin
      if (m_took) m_gap = calm ? 0 : $urandom_range(0, 9);
      if (m_gap > 0) begin
        m_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  verdict_t want;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status expected %0d actual %0d", want.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[31:0] !== want.wait_time) begin
          $error("wait_time expected %0d actual %0d", want.wait_time, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[38:32] !== want.in_flight) begin
          $error("in_flight expected %0d actual %0d", want.in_flight, m_axis_tdata[38:32]);
          errors++;
        end
      end
    end
  end

  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_requests.size() == 0 && expected_verdicts.size() == 0 && !s_axis_tvalid))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_IN_FLIGHT:   lim_r = 64'(val[6:0]);
      REG_MIN_FREE_MEMORY: floor_r = 64'(val);
      default:             smooth_r = 64'(val[0]);
    endcase
  endtask

  // A fresh window is forced whenever pacing is on, so no stale ring slot is ever read.
  task automatic set_mode(logic [6:0] lim, logic [47:0] floor_val, logic smooth);
    if (smooth && lim != 0 && lim <= 64 && lim == win_size[6:0])
      lim = (lim == 64) ? 7'd63 : lim + 7'd1;
    write_reg(REG_MAX_IN_FLIGHT, {41'd0, lim});
    write_reg(REG_MIN_FREE_MEMORY, floor_val);
    write_reg(REG_SMOOTH_ENABLE, {47'd0, smooth});
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && !s_axis_tvalid && expected_verdicts.size() == 0);
    repeat (450) @(posedge clk);
  endtask

  logic [39:0] clock_us = 40'd1000;
  logic [39:0] issued = 0;

  task automatic queue_item(logic cmd, logic [39:0] ct, logic [39:0] now, logic [47:0] mem);
    request_t r;
    r.cmd = cmd;
    r.consumed_total = ct;
    r.now_time = now;
    r.free_memory = mem;
    if (cmd == CMD_PUBLISH) issued++;
    pending_requests.push_back(r);
  endtask

  task automatic random_items(int count);
    logic [39:0] ct, now;
    logic [47:0] mem;
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      clock_us += $urandom_range(0, 3000);
      now = ($urandom_range(0, 29) == 0) ? 40'({$urandom, $urandom}) : clock_us;
      case ($urandom_range(0, 3))
        0:       mem = 48'({$urandom, $urandom});
        1:       mem = floor_r[47:0] + $urandom_range(0, 2) - 1;
        default: mem = floor_r[47:0] + $urandom_range(1, 1 << 20);
      endcase
      if (k < 30) begin
        if (k < 3) ct = 40'({$urandom, $urandom});
        else if (k < 6) ct = issued + $urandom_range(1, 50);
        else ct = issued - $urandom_range(0, lim_r[6:0] + 2);
        queue_item(CMD_FEEDBACK, ct, 40'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      end else begin
        queue_item(CMD_PUBLISH, 40'({$urandom, $urandom}), now, mem);
      end
    end
  endtask

  initial begin
    lim_r = 0; floor_r = 0; smooth_r = 0;
    sent_cnt = 0; done_cnt = 0; win_size = 0; win_start = 0;
    first_t = 0; last_t = 0; delay_q8 = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Both checks off: grants with no wait and no count, plus field extremes.
    queue_item(CMD_FEEDBACK, '0, '0, '0);
    queue_item(CMD_PUBLISH, '1, '0, '0);
    queue_item(CMD_PUBLISH, '0, '1, '1);
    queue_item(CMD_FEEDBACK, '1, '1, '1);
    queue_item(CMD_PUBLISH, '0, 40'd5, 48'd0);
    drain();

    // Credit limit of one with memory floor: credit holds, memory holds, consumed above sent.
    set_mode(7'd1, 48'd1000, 1'b1);
    queue_item(CMD_FEEDBACK, '0, '0, '0);
    queue_item(CMD_PUBLISH, '0, 40'd100, 48'd1001);
    queue_item(CMD_PUBLISH, '0, 40'd200, 48'd2000);
    queue_item(CMD_FEEDBACK, 40'd1, '0, '0);
    queue_item(CMD_PUBLISH, '0, 40'd300, 48'd1000);
    queue_item(CMD_PUBLISH, '0, 40'd400, 48'd0);
    queue_item(CMD_PUBLISH, '0, 40'd500, '1);
    queue_item(CMD_FEEDBACK, 40'd2, '0, '0);
    queue_item(CMD_PUBLISH, '0, 40'd900, 48'd5000);
    queue_item(CMD_FEEDBACK, 40'd10, '0, '0);
    queue_item(CMD_PUBLISH, '0, 40'd950, 48'd5000);
    queue_item(CMD_FEEDBACK, '1, '0, '0);
    queue_item(CMD_PUBLISH, '0, '1, 48'd5000);
    drain();

    // Limit beyond the ring, then the largest floor so memory always holds.
    set_mode(7'd127, 48'd0, 1'b1);
    random_items(30);
    drain();
    set_mode(7'd64, '1, 1'b1);
    random_items(20);
    drain();

    for (int p = 0; p < 14; p++) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       set_mode(7'd0, 48'({$urandom, $urandom}), 1'($urandom));
        1:       set_mode(7'd64, 48'd0, 1'b1);
        2:       set_mode(7'($urandom_range(65, 127)), 48'($urandom_range(0, 1000)),
                          1'($urandom));
        default: set_mode(7'($urandom_range(1, 8)), ($urandom_range(0, 1) ? 48'd0 :
                          48'($urandom_range(1, 100000))), $urandom_range(0, 3) != 0);
      endcase
      random_items(65);
      drain();
    end
    calm = 0;

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/icpl_pkg.sv
src/icpl_ram.sv
src/icpl_div.sv
src/inflight_credit_pacing_limiter.sv
src/icpl_checker.sv
tb/tb_top.sv
